[hdl/d6sp_pkg.sv]
package d6sp_pkg;

  localparam int MAX_VERTICES = 62;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [7:0] CHAR_OFFSET = 8'd63;
  localparam logic [7:0] CHAR_LIMIT = 8'd126;
  localparam logic [7:0] CHAR_AMP = 8'h26;
  localparam logic [2:0] BITS_PER_CHAR = 3'd6;
  localparam logic [2:0] TOP_BIT = 3'd5;

  typedef enum logic [1:0] {
    KIND_EDGE  = 2'd0,
    KIND_ORDER = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic {
    ERR_TOO_LARGE = 1'b0,
    ERR_TOO_SMALL = 1'b1
  } err_t;

  typedef enum logic [2:0] {
    PH_ORDER = 3'b001,
    PH_DATA  = 3'b010,
    PH_DONE  = 3'b100
  } phase_t;

  // one queued word: an order report, an error, or a run of adjacency bits
  typedef struct packed {
    kind_t      kind;
    err_t       err;
    logic [5:0] count;
    logic [5:0] frag;
    logic [2:0] nbits;
  } task_t;

  typedef struct packed {
    logic  push;
    task_t tsk;
  } push_t;

  typedef struct packed {
    logic  valid;
    task_t tsk;
  } head_t;

endpackage

[hdl/d6sp_front.sv]
module d6sp_front #(
  parameter int MAX_VERTICES = d6sp_pkg::MAX_VERTICES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,
  input  logic [0:0]        s_tuser,
  input  logic              q_full,
  output d6sp_pkg::push_t   q_push
);

  d6sp_pkg::phase_t phase, phase_next;
  logic [11:0] rem, rem_next;
  logic [7:0]  val;
  logic [11:0] sq;
  logic [2:0]  nb;
  logic        accept;
  d6sp_pkg::phase_t eff_phase;
  d6sp_pkg::task_t  tsk;
  logic             tsk_valid;

  assign s_tready = !q_full;
  assign accept = s_tvalid && s_tready;
  assign val = s_tdata - d6sp_pkg::CHAR_OFFSET;
  assign sq = {6'd0, val[5:0]} * {6'd0, val[5:0]};
  assign nb = (rem >= 12'(d6sp_pkg::BITS_PER_CHAR)) ? d6sp_pkg::BITS_PER_CHAR : rem[2:0];
  assign eff_phase = s_tuser[0] ? d6sp_pkg::PH_ORDER : phase;

  always_comb begin
    tsk = '0;
    tsk_valid = 1'b0;
    phase_next = phase;
    rem_next = rem;
    if (s_tuser[0] && s_tdata == d6sp_pkg::CHAR_AMP) begin
      phase_next = d6sp_pkg::PH_ORDER;
    end else begin
      case (eff_phase)
        d6sp_pkg::PH_ORDER: begin
          tsk_valid = 1'b1;
          phase_next = d6sp_pkg::PH_DONE;
          if (s_tdata < d6sp_pkg::CHAR_OFFSET) begin
            tsk.kind = d6sp_pkg::KIND_ERROR;
            tsk.err = d6sp_pkg::ERR_TOO_SMALL;
          end else if (s_tdata >= d6sp_pkg::CHAR_LIMIT || val > 8'(MAX_VERTICES)) begin
            tsk.kind = d6sp_pkg::KIND_ERROR;
            tsk.err = d6sp_pkg::ERR_TOO_LARGE;
          end else begin
            tsk.kind = d6sp_pkg::KIND_ORDER;
            tsk.count = val[5:0];
            rem_next = sq;
            if (val != 8'd0) phase_next = d6sp_pkg::PH_DATA;
          end
        end
        d6sp_pkg::PH_DATA: begin
          tsk_valid = 1'b1;
          if (s_tdata < d6sp_pkg::CHAR_OFFSET) begin
            tsk.kind = d6sp_pkg::KIND_ERROR;
            tsk.err = d6sp_pkg::ERR_TOO_SMALL;
          end else begin
            tsk.kind = d6sp_pkg::KIND_EDGE;
            tsk.frag = val[5:0];
            tsk.nbits = nb;
            rem_next = rem - 12'(nb);
            if (rem == 12'(nb)) phase_next = d6sp_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign q_push.push = accept && tsk_valid;
  assign q_push.tsk = tsk;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= d6sp_pkg::PH_ORDER;
      rem <= 12'd0;
    end else if (accept) begin
      phase <= phase_next;
      rem <= rem_next;
    end
  end

endmodule

[hdl/d6sp_queue.sv]
module d6sp_queue (
  input  logic            clk,
  input  logic            rst,
  input  d6sp_pkg::push_t q_push,
  output logic            q_full,
  input  logic            pop,
  output d6sp_pkg::head_t head
);

  d6sp_pkg::task_t slots [d6sp_pkg::QUEUE_DEPTH];
  logic [d6sp_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [d6sp_pkg::QPTR_W:0]   fill;
  logic                        do_push, do_pop;

  assign q_full = (fill == (d6sp_pkg::QPTR_W + 1)'(d6sp_pkg::QUEUE_DEPTH));
  assign head.valid = (fill != '0);
  assign head.tsk = slots[rd_ptr];
  assign do_push = q_push.push && !q_full;
  assign do_pop = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) fill <= fill + 1'b1;
      else if (!do_push && do_pop) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= q_push.tsk;
  end

endmodule

[hdl/d6sp_back.sv]
module d6sp_back #(
  parameter int MAX_VERTICES = d6sp_pkg::MAX_VERTICES
) (
  input  logic            clk,
  input  logic            rst,
  input  d6sp_pkg::head_t head,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [31:0]     m_tdata,
  output logic [1:0]      m_tuser,
  output logic            m_tlast
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  typedef struct packed {
    d6sp_pkg::kind_t kind;
    logic [5:0]      src;
    logic [5:0]      tgt;
    logic            pres;
    logic [5:0]      count;
    d6sp_pkg::err_t  err;
    logic            last;
  } slot_t;

  typedef struct packed {
    d6sp_pkg::kind_t kind;
    logic [5:0]      src;
    logic [5:0]      tgt;
    logic            pres;
    logic [5:0]      od;
    logic [5:0]      id;
    logic [5:0]      count;
    d6sp_pkg::err_t  err;
    logic            last;
  } result_t;

  logic [5:0] held_n, held_n_next;
  logic [5:0] row, row_next;
  logic [5:0] col, col_next;
  logic [2:0] bit_idx, bit_idx_next;
  slot_t      slot, p1;
  logic       p1_valid;
  result_t    res, out;
  logic       out_valid;
  logic       adv;

  logic [5:0]              in_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] vld;
  logic [5:0]              rd, fwd_val, row_deg;
  logic                    rd_vld, fwd;
  logic [5:0]              in_base, id, od;
  logic                    p1_edge, p1_order;

  assign adv = !out_valid || m_tready;

  // sequencer: one slot per cycle from the queue head, while the output can advance
  always_comb begin
    slot = '0;
    pop = 1'b0;
    held_n_next = held_n;
    row_next = row;
    col_next = col;
    bit_idx_next = bit_idx;
    if (head.valid) begin
      case (head.tsk.kind)
        d6sp_pkg::KIND_ORDER: begin
          slot.kind = d6sp_pkg::KIND_ORDER;
          slot.count = head.tsk.count;
          slot.last = 1'b1;
          held_n_next = head.tsk.count;
          row_next = 6'd0;
          col_next = 6'd0;
          pop = adv;
        end
        d6sp_pkg::KIND_ERROR: begin
          slot.kind = d6sp_pkg::KIND_ERROR;
          slot.err = head.tsk.err;
          slot.last = 1'b1;
          pop = adv;
        end
        default: begin
          slot.kind = d6sp_pkg::KIND_EDGE;
          slot.src = row;
          slot.tgt = col;
          slot.pres = head.tsk.frag[d6sp_pkg::TOP_BIT - bit_idx];
          slot.count = held_n;
          slot.last = (bit_idx == head.tsk.nbits - 3'd1);
          if (col == held_n - 6'd1) begin
            col_next = 6'd0;
            row_next = row + 6'd1;
          end else begin
            col_next = col + 6'd1;
          end
          if (slot.last) begin
            bit_idx_next = 3'd0;
            pop = adv;
          end else begin
            bit_idx_next = bit_idx + 3'd1;
          end
        end
      endcase
    end
  end

  // degree update
  assign p1_edge = p1_valid && p1.kind == d6sp_pkg::KIND_EDGE;
  assign p1_order = p1_valid && p1.kind == d6sp_pkg::KIND_ORDER;
  assign in_base = fwd ? fwd_val : (rd_vld ? rd : 6'd0);
  assign id = in_base + {5'd0, p1.pres};
  assign od = ((p1.tgt == 6'd0) ? 6'd0 : row_deg) + {5'd0, p1.pres};

  always_comb begin
    res.kind = p1.kind;
    res.src = p1.src;
    res.tgt = p1.tgt;
    res.pres = p1.pres;
    res.od = (p1.kind == d6sp_pkg::KIND_EDGE) ? od : 6'd0;
    res.id = (p1.kind == d6sp_pkg::KIND_EDGE) ? id : 6'd0;
    res.count = p1.count;
    res.err = p1.err;
    res.last = p1.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      out_valid <= 1'b0;
      held_n <= 6'd0;
      row <= 6'd0;
      col <= 6'd0;
      bit_idx <= 3'd0;
      vld <= '0;
      rd_vld <= 1'b0;
      fwd <= 1'b0;
    end else if (adv) begin
      p1_valid <= head.valid;
      out_valid <= p1_valid;
      held_n <= held_n_next;
      row <= row_next;
      col <= col_next;
      bit_idx <= bit_idx_next;
      if (p1_order) vld <= '0;
      else if (p1_edge) vld[p1.tgt[AW-1:0]] <= 1'b1;
      rd_vld <= vld[slot.tgt[AW-1:0]] && !p1_order;
      fwd <= p1_edge && head.valid && slot.kind == d6sp_pkg::KIND_EDGE
             && slot.tgt == p1.tgt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1 <= slot;
      rd <= in_mem[slot.tgt[AW-1:0]];
      fwd_val <= id;
      out <= res;
      if (p1_edge) begin
        in_mem[p1.tgt[AW-1:0]] <= id;
        row_deg <= od;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {out.err, out.count, out.id, out.od, out.pres, out.tgt, out.src};
  assign m_tuser = out.kind;
  assign m_tlast = out.last;

endmodule

[hdl/digraph6_stream_parser_core.sv]
// channel  dir  tdata (low bit up)                              tuser          tlast
// s_*      in   data_byte[7:0]                                  start_of_string  -
// m_*      out  source_vertex[5:0] target_vertex[5:0]           kind[1:0]      last_of_run
//               edge_present source_out_degree[5:0]
//               target_in_degree[5:0] vertex_count[5:0] error_code
//
// One result word per cycle while words are queued and m_tready allows. A data byte
// yields 1 to 6 result words, one per adjacency bit; order and error bytes yield one;
// a skipped '&' or an ignored byte yields none. The rate is set by the back-end bit
// sequencer and the single write port of the in-degree memory.
// Synchronous reset clears all control state; the degree valid bits clear at once.
// A four-word queue parts the input from the back end, so either side stalls alone.
module digraph6_stream_parser_core #(
  parameter int MAX_VERTICES = d6sp_pkg::MAX_VERTICES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic [0:0]  s_tuser,   // start_of_string
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // source_vertex, target_vertex, edge_present,
                                 // source_out_degree, target_in_degree,
                                 // vertex_count, error_code
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast    // last_of_run
);

  d6sp_pkg::push_t q_push;
  d6sp_pkg::head_t head;
  logic            q_full;
  logic            pop;

  d6sp_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push)
  );

  d6sp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .q_full (q_full),
    .pop    (pop),
    .head   (head)
  );

  d6sp_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

[bench/d6sp_checker.sv]
module d6sp_checker
  import d6sp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic [0:0]  s_tuser,   // start_of_string
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // source_vertex, target_vertex, edge_present,
                                 // source_out_degree, target_in_degree,
                                 // vertex_count, error_code
  input  logic [1:0]  m_tuser,   // kind
  input  logic        m_tlast,   // last_of_run
  output int          fail_count,
  output int          words_pending,
  output int          words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    kind_t      kind;
    logic [5:0] src;
    logic [5:0] dst;
    logic       present;
    logic [5:0] out_deg;
    logic [5:0] in_deg;
    logic [5:0] count;
    err_t       code;
    logic       last;
  } graph_word_t;

  graph_word_t expected_words[$];

  phase_t     phase;
  logic [5:0] order_n;
  logic [5:0] row;
  logic [5:0] col;
  int         bytes_left;
  logic [5:0] out_deg_tbl[MAX_VERTICES];
  logic [5:0] in_deg_tbl[MAX_VERTICES];

  task automatic clear_degrees();
    for (int v = 0; v < MAX_VERTICES; v++) begin
      out_deg_tbl[v] = '0;
      in_deg_tbl[v] = '0;
    end
  endtask

  // order reports and errors: one word, all edge fields zero
  function automatic graph_word_t status_word(kind_t k, logic [5:0] cnt, err_t code);
    graph_word_t w;
    w = '{kind: k, src: '0, dst: '0, present: 1'b0, out_deg: '0, in_deg: '0,
          count: cnt, code: code, last: 1'b1};
    return w;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic sos);
    graph_word_t run[6];
    logic [5:0]  frag;
    logic [5:0]  u;
    logic [5:0]  v;
    logic        bit_set;
    int          k;
    k = 0;
    if (sos) begin
      phase = PH_ORDER;
      clear_degrees();
      if (b == CHAR_AMP) return;
    end
    if (phase == PH_ORDER) begin
      if (b < CHAR_OFFSET) begin
        expected_words.push_back(status_word(KIND_ERROR, '0, ERR_TOO_SMALL));
        phase = PH_DONE;
      end else if (b >= CHAR_LIMIT || (b - CHAR_OFFSET) > 8'(MAX_VERTICES)) begin
        expected_words.push_back(status_word(KIND_ERROR, '0, ERR_TOO_LARGE));
        phase = PH_DONE;
      end else begin
        order_n = 6'(b - CHAR_OFFSET);
        row = '0;
        col = '0;
        bytes_left = (int'(order_n) * int'(order_n) + 5) / 6;
        clear_degrees();
        phase = (order_n == 0) ? PH_DONE : PH_DATA;
        // code field reads zero on order words
        expected_words.push_back(status_word(KIND_ORDER, order_n, ERR_TOO_LARGE));
      end
      return;
    end
    if (phase != PH_DATA) return;
    if (b < CHAR_OFFSET) begin
      expected_words.push_back(status_word(KIND_ERROR, '0, ERR_TOO_SMALL));
      return;
    end
    frag = 6'(b - CHAR_OFFSET);
    for (int i = 0; i < 6 && row < order_n; i++) begin
      u = row;
      v = col;
      bit_set = frag[5 - i];
      if (bit_set) begin
        if (out_deg_tbl[u] != 6'd63) out_deg_tbl[u]++;
        if (in_deg_tbl[v] != 6'd63) in_deg_tbl[v]++;
      end
      run[k] = '{kind: KIND_EDGE, src: u, dst: v, present: bit_set,
                 out_deg: out_deg_tbl[u], in_deg: in_deg_tbl[v], count: order_n,
                 code: ERR_TOO_LARGE, last: 1'b0};
      k++;
      col++;
      if (col == order_n) begin
        col = '0;
        row++;
      end
    end
    if (bytes_left > 0) bytes_left--;
    if (bytes_left == 0 || row >= order_n) phase = PH_DONE;
    for (int j = 0; j < k; j++) begin
      run[j].last = (j == k - 1);
      expected_words.push_back(run[j]);
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_word(input logic [31:0] d, input logic [1:0] k, input logic l);
    graph_word_t e;
    if (expected_words.size() == 0) begin
      $error("unexpected result word: kind %0d tdata %h last %0d", k, d, l);
      fail_count++;
      return;
    end
    e = expected_words.pop_front();
    check_field("kind", e.kind, k);
    check_field("source_vertex", e.src, d[5:0]);
    check_field("target_vertex", e.dst, d[11:6]);
    check_field("edge_present", e.present, d[12]);
    check_field("source_out_degree", e.out_deg, d[18:13]);
    check_field("target_in_degree", e.in_deg, d[24:19]);
    check_field("vertex_count", e.count, d[30:25]);
    check_field("error_code", e.code, d[31]);
    check_field("last_of_run", e.last, l);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase = PH_ORDER;
      order_n = '0;
      row = '0;
      col = '0;
      bytes_left = 0;
      clear_degrees();
      expected_words.delete();
    end else begin
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tuser[0]);
      if (m_tvalid && m_tready) begin
        check_word(m_tdata, m_tuser, m_tlast);
        words_checked++;
      end
    end
    words_pending = expected_words.size();
  end

endmodule

[bench/digraph6_stream_parser_core_tb.sv]
module digraph6_stream_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import d6sp_pkg::*;

  localparam int RANDOM_BYTES = 200;
  localparam int IDLE_LIMIT = 500;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_SPARSE,
    RX_PERIODIC,
    RX_COIN
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  int fail_count;
  int words_pending;
  int words_checked;

  int       burst_left = 0;
  int       bytes_sent = 0;
  int       strings_sent = 0;
  int       parsed_bytes = 0;
  int       idle_cycles = 0;
  int       cyc = 0;
  rx_mode_t rx_mode = RX_OPEN;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  digraph6_stream_parser_core dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  d6sp_checker chk (.*);

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 64 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:     m_tready <= 1'b1;
      RX_SPARSE:   m_tready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: m_tready <= (cyc % 16 < 11);
      default:     m_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    do @(posedge clk); while (idle_cycles < IDLE_LIMIT);
    $display("stalled: no word moved for %0d cycles", IDLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic sos);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                : $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= sos;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_string();
    int         n;
    int         nbytes;
    int         pick;
    logic       sos_on_order;
    logic [7:0] b;
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 62) : $urandom_range(0, 9);
    strings_sent++;
    sos_on_order = 1'b1;
    if ($urandom_range(0, 1) == 1) begin
      send_byte(CHAR_AMP, 1'b1);
      sos_on_order = 1'b0;
    end
    if ($urandom_range(0, 9) == 0) b = 8'($urandom_range(0, 255));
    else b = CHAR_OFFSET + 8'(n);
    send_byte(b, sos_on_order);
    parsed_bytes++;
    nbytes = (n * n + 5) / 6;
    if (nbytes > 24) nbytes = 24;
    if ($urandom_range(0, 4) == 0) nbytes = $urandom_range(0, nbytes);
    for (int i = 0; i < nbytes; i++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) b = 8'($urandom_range(0, 62));
      else if (pick < 3) b = 8'($urandom_range(127, 255));
      else b = 8'($urandom_range(63, 126));
      send_byte(b, 1'b0);
      parsed_bytes++;
    end
    // trailing noise after the data bytes
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_byte(8'h00, 1'b0);          // order byte too small straight out of reset
    send_byte(8'hFF, 1'b0);          // ignored while done
    send_byte(CHAR_AMP, 1'b1);
    send_byte(CHAR_LIMIT, 1'b0);     // order too large
    send_byte(8'hFF, 1'b1);          // too large on a start byte
    send_byte(CHAR_OFFSET, 1'b1);    // empty digraph
    send_byte(8'd100, 1'b0);         // ignored
    send_byte(CHAR_AMP, 1'b1);
    send_byte(CHAR_AMP, 1'b0);       // '&' as an order byte is an error
    send_byte(CHAR_AMP, 1'b1);
    send_byte(8'd65, 1'b0);          // n = 2
    send_byte(CHAR_LIMIT, 1'b0);     // all four arcs
    send_byte(8'd80, 1'b0);          // past the matrix, ignored
    send_byte(8'd64, 1'b1);          // n = 1
    send_byte(CHAR_AMP, 1'b0);       // data byte too small, position holds
    send_byte(8'd127, 1'b0);         // wraps to zero bits
    send_byte(8'd125, 1'b1);         // n = 62
    send_byte(CHAR_OFFSET, 1'b0);
    send_byte(CHAR_LIMIT, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'd190, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'd85, 1'b0);
    send_byte(8'd66, 1'b1);          // n = 3, partial final byte
    send_byte(CHAR_LIMIT, 1'b0);
    send_byte(CHAR_LIMIT, 1'b0);
    send_byte(8'd62, 1'b1);          // order byte just below range
    strings_sent = 10;

    while (parsed_bytes < RANDOM_BYTES) send_string();
    s_tvalid <= 1'b0;

    do @(negedge clk); while (words_pending != 0);
    repeat (8) @(negedge clk);

    $display("sent %0d bytes in %0d strings (directed corners plus random digraphs)",
             bytes_sent, strings_sent);
    $display("checked %0d result words, %0d mismatches", words_checked, fail_count);
    if (fail_count == 0 && words_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
